// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the square cover check RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: %m");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: %m");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ===== rtl/core/sccc_pkg.sv =====
// Types, constants and helpers of the 2x2 square cover check.
`default_nettype none
package sccc_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  // column and row counters
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  // configuration register width
  localparam int CNT_W = 7;
  // result field widths
  localparam int POS_W   = 6;
  localparam int TOTAL_W = 12;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [CNT_W-1:0]   CNT_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0]   ROW_LIMIT = CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0]   COL_LIMIT = CNT_W'(MAX_COLS);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  // output queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  // one entry of the line memory: pixel of the row above and its coverage mark
  typedef struct packed {
    logic pix;
    logic mark;
  } line_t;

  typedef struct packed {
    logic [POS_W-1:0]   square_row;
    logic [POS_W-1:0]   square_col;
    logic               is_summary;
    logic               all_covered;
    logic [TOTAL_W-1:0] square_count;
    logic               last;
  } result_t;

  // results produced by one item: a square first, then the summary
  typedef struct packed {
    logic    sq_push;
    logic    sum_push;
    result_t sq;
    result_t sum;
  } push_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] res;
    res = v;
    if (v < CNT_MIN) begin
      res = CNT_MIN;
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sccc_line_mem.sv =====
// Line memory: one {pixel, mark} entry per column, valid bits, write-through read.
`default_nettype none
module sccc_line_mem (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       we,
  input  wire logic [sccc_pkg::COL_W-1:0] waddr,
  input  wire sccc_pkg::line_t            wdata,
  input  wire logic [sccc_pkg::COL_W-1:0] raddr,
  output sccc_pkg::line_t                 rdata
);

  sccc_pkg::line_t                 mem [sccc_pkg::MAX_COLS];
  logic [sccc_pkg::MAX_COLS-1:0]   valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // forward a same-edge write; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else if (valid[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      rdata <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sccc_scan.sv =====
// Pixel scan: position counters, square detection, coverage check, summary.
`default_nettype none
`include "assert_macros.svh"
module sccc_scan (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic                       pixel,
  input  wire logic [sccc_pkg::CNT_W-1:0] row_count,
  input  wire logic [sccc_pkg::CNT_W-1:0] col_count,
  output sccc_pkg::push_t                 push
);

  logic [sccc_pkg::COL_W-1:0]   col_counter;
  logic [sccc_pkg::ROW_W-1:0]   row_counter;
  logic [sccc_pkg::COL_W-1:0]   col_next;
  logic [sccc_pkg::TOTAL_W-1:0] square_total;
  logic [sccc_pkg::TOTAL_W-1:0] square_total_next;
  logic                         failed_flag;
  logic                         left_pixel;
  logic                         prev_above;
  logic                         prev_mark;
  logic                         prev_sq;
  logic                         pend_valid;
  logic [sccc_pkg::COL_W-1:0]   pend_addr;
  sccc_pkg::line_t              pend_data;

  logic                         mem_we;
  logic [sccc_pkg::COL_W-1:0]   mem_waddr;
  sccc_pkg::line_t              mem_wdata;
  logic [sccc_pkg::COL_W-1:0]   mem_raddr;
  sccc_pkg::line_t              rd;

  logic c_nz, r_nz, eol, last_row, eoi;
  logic above, aboveleft, left, sq, mark, fail_now;

  sccc_line_mem u_line_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  always_comb begin
    c_nz     = (col_counter != '0);
    r_nz     = (row_counter != '0);
    eol      = ({1'b0, col_counter} + 7'd1) >= col_count;
    last_row = ({1'b0, row_counter} + 7'd1) >= row_count;
    eoi      = eol && last_row;

    above     = r_nz && rd.pix;
    aboveleft = r_nz && c_nz && prev_above;
    left      = c_nz && left_pixel;
    sq        = pixel && left && above && aboveleft;
    mark      = prev_sq || sq;

    fail_now = (c_nz && r_nz && prev_above && !(prev_mark || prev_sq || sq))
            || (c_nz && last_row && left && !mark)
            || (eol && r_nz && rd.pix && !(rd.mark || sq))
            || (eol && last_row && pixel && !sq);

    square_total_next = square_total;
    if (sq && square_total != sccc_pkg::TOTAL_MAX) begin
      square_total_next = square_total + 1'b1;
    end

    if (eol) begin
      col_next = '0;
    end else begin
      col_next = col_counter + 1'b1;
    end

    // prefetch the entry of the next pixel's column
    mem_raddr = accept ? col_next : col_counter;

    // the end-of-row write is deferred into the pend registers; the next
    // item sits in column zero and writes nothing, so the port is free
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = pend_data;
    if (accept && c_nz) begin
      mem_we    = 1'b1;
      mem_waddr = col_counter - 1'b1;
      mem_wdata = '{pix: left, mark: mark};
    end else if (pend_valid) begin
      mem_we = 1'b1;
    end

    push                  = '0;
    push.sq_push          = accept && sq;
    push.sq.square_row    = sccc_pkg::POS_W'(row_counter - 1'b1);
    push.sq.square_col    = sccc_pkg::POS_W'(col_counter - 1'b1);
    push.sum_push         = accept && eoi;
    push.sum.is_summary   = 1'b1;
    push.sum.all_covered  = !(failed_flag || fail_now);
    push.sum.square_count = square_total_next;
    push.sum.last         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_counter  <= '0;
      row_counter  <= '0;
      square_total <= '0;
      failed_flag  <= 1'b0;
      left_pixel   <= 1'b0;
      prev_above   <= 1'b0;
      prev_mark    <= 1'b0;
      prev_sq      <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      pend_valid <= accept && eol;
      if (accept) begin
        left_pixel <= pixel;
        prev_above <= rd.pix;
        prev_mark  <= rd.mark;
        prev_sq    <= sq;
        if (eoi) begin
          col_counter  <= '0;
          row_counter  <= '0;
          square_total <= '0;
          failed_flag  <= 1'b0;
        end else begin
          col_counter  <= col_next;
          square_total <= square_total_next;
          failed_flag  <= failed_flag || fail_now;
          if (eol) begin
            row_counter <= row_counter + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && eol) begin
      pend_addr <= col_counter;
      pend_data <= '{pix: pixel, mark: sq};
    end
  end

  `ASSERT_PROP(a_sum_clears, clk, rst, push.sum_push |=> (col_counter == '0 && row_counter == '0 && square_total == '0))
  `ASSERT_PROP(a_sq_inside, clk, rst, push.sq_push |-> (col_counter != '0 && row_counter != '0))

endmodule
`default_nettype wire

// ===== rtl/core/sccc_out_queue.sv =====
// Output queue: takes up to two results per cycle, hands out one per cycle while out_ready is high.
`default_nettype none
`include "assert_macros.svh"
module sccc_out_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sccc_pkg::push_t   push,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sccc_pkg::result_t      head
);

  sccc_pkg::result_t               entries [sccc_pkg::OUT_DEPTH];
  logic [sccc_pkg::OUT_AW-1:0]     wr_ptr;
  logic [sccc_pkg::OUT_AW-1:0]     rd_ptr;
  logic [sccc_pkg::OUT_CW-1:0]     count;
  logic [sccc_pkg::OUT_AW-1:0]     sum_ptr;
  logic [1:0]                      n_push;
  logic                            pop;

  always_comb begin
    out_valid = (count != '0);
    head      = entries[rd_ptr];
    pop       = out_valid && out_ready;
    // an item may bring two results: keep two slots free before taking one
    room      = count <= sccc_pkg::OUT_CW'(sccc_pkg::OUT_DEPTH - 2);
    n_push    = {1'b0, push.sq_push} + {1'b0, push.sum_push};
    sum_ptr   = wr_ptr + sccc_pkg::OUT_AW'(push.sq_push);
  end

  always_ff @(posedge clk) begin
    if (push.sq_push) begin
      entries[wr_ptr] <= push.sq;
    end
    if (push.sum_push) begin
      entries[sum_ptr] <= push.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + sccc_pkg::OUT_AW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + sccc_pkg::OUT_CW'(n_push) - sccc_pkg::OUT_CW'(pop);
    end
  end

  `ASSERT_NEVER(a_count_bound, clk, rst, count > sccc_pkg::OUT_CW'(sccc_pkg::OUT_DEPTH))
  `ASSERT_PROP(a_push_room, clk, rst, (push.sq_push || push.sum_push) |-> count <= sccc_pkg::OUT_CW'(sccc_pkg::OUT_DEPTH - 2))

endmodule
`default_nettype wire

// ===== rtl/core/binary_image_2x2_square_cover_check_unit.sv =====
// Top level of the 2x2 square cover check: config registers, scan, output queue.
`default_nettype none
// Streams a binary image in row-major order, one pixel per item, and reports
// every 2x2 block of set pixels by its top-left row and column, in row-major
// order, as it completes (when its bottom-right pixel arrives). After the last
// pixel of the image a summary item follows with the square count (saturating
// at 4095) and all_covered, which is 1 only if every set pixel lies in at least
// one square; discard the squares of an image whose summary has all_covered
// clear. The summary carries last = 1. Image size comes from row_count (index 0)
// and col_count (index 1), each clamped to 2..64; write them only between items.
// Throughput is one pixel per cycle while in_ready is high: the row above is
// kept in a 64-entry line memory whose read for the next column is issued as
// the current pixel is accepted, and each pixel does one read-modify-write of
// that memory. A result enters the output queue in the cycle its pixel is
// accepted. The output queue holds four results; in_ready drops while fewer
// than two slots are free, so with a stalled consumer the pixel stream halts
// once three results wait; pixels that bring no result keep flowing until then.
module binary_image_2x2_square_cover_check_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration writes
  input  wire logic                           cfg_write,
  input  wire logic [sccc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sccc_pkg::CNT_W-1:0]     cfg_data,
  // pixel items
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           pixel,
  // result items
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [sccc_pkg::POS_W-1:0]          square_row,
  output logic [sccc_pkg::POS_W-1:0]          square_col,
  output logic                                is_summary,
  output logic                                all_covered,
  output logic [sccc_pkg::TOTAL_W-1:0]        square_count,
  output logic                                last
);

  logic [sccc_pkg::CNT_W-1:0] row_count;
  logic [sccc_pkg::CNT_W-1:0] col_count;
  logic                       accept;
  logic                       room;
  sccc_pkg::push_t            push;
  sccc_pkg::result_t          head;

  // Hold the clamped register values; out-of-range writes snap to the limits.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= sccc_pkg::ROW_LIMIT;
      col_count <= sccc_pkg::COL_LIMIT;
    end else if (cfg_write) begin
      case (cfg_index)
        sccc_pkg::CFG_ROW_COUNT: begin
          row_count <= sccc_pkg::clamp_count(cfg_data, sccc_pkg::ROW_LIMIT);
        end
        sccc_pkg::CFG_COL_COUNT: begin
          col_count <= sccc_pkg::clamp_count(cfg_data, sccc_pkg::COL_LIMIT);
        end
        default: begin
        end
      endcase
    end
  end

  // Take a pixel whenever the queue can absorb both possible results.
  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  sccc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .pixel     (pixel),
    .row_count (row_count),
    .col_count (col_count),
    .push      (push)
  );

  sccc_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Drive the result fields from the queue head.
  assign square_row   = head.square_row;
  assign square_col   = head.square_col;
  assign is_summary   = head.is_summary;
  assign all_covered  = head.all_covered;
  assign square_count = head.square_count;
  assign last         = head.last;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the streamed 2x2 square cover check unit.
`timescale 1ns / 1ps

module testbench;
  import sccc_pkg::*;

  localparam int PIXEL_TARGET   = 1850;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int TAIL_CYCLES    = 8;
  localparam int SQUARE_LIMIT   = 4095;
  localparam int PRINT_LIMIT    = 40;

  // Tracks the scan position, the line of the row above and the coverage
  // marks, and keeps the results that the unit still owes, oldest first.
  class square_tracker;
    int rows;
    int cols;
    bit above_pix[MAX_COLS];
    bit square_at[MAX_COLS];
    bit cover_mark[MAX_COLS];
    bit left_pix;
    int row_pos;
    int col_pos;
    int found;
    bit uncovered;
    result_t due_results[$];
    int mismatches;

    function new();
      rows = MAX_ROWS;
      cols = MAX_COLS;
      foreach (above_pix[i]) begin
        above_pix[i] = 1'b0;
        square_at[i] = 1'b0;
        cover_mark[i] = 1'b0;
      end
      left_pix = 1'b0;
      row_pos = 0;
      col_pos = 0;
      found = 0;
      uncovered = 1'b0;
      mismatches = 0;
    endfunction

    function int clamp_reg(input int raw, input int hi);
      if (raw < 2) return 2;
      if (raw > hi) return hi;
      return raw;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
      if (idx == CFG_ROW_COUNT) rows = clamp_reg(int'(val), MAX_ROWS);
      else if (idx == CFG_COL_COUNT) cols = clamp_reg(int'(val), MAX_COLS);
    endfunction

    function bit at_frame_start();
      return (row_pos == 0) && (col_pos == 0);
    endfunction

    function void mark_uncovered(input bit pix, input bit covered);
      if (pix && !covered) uncovered = 1'b1;
    endfunction

    // Append a result to the tail of the owed list.
    function void queue_result(input result_t res);
      due_results = {due_results, res};
    endfunction

    function void take_pixel(input bit p);
      int c;
      int r;
      bit eol;
      bit last_row;
      bit above;
      bit aboveleft;
      bit left;
      bit prior;
      bit sq;
      bit mark;
      result_t res;
      c = col_pos;
      r = row_pos;
      if (c >= MAX_COLS) c = MAX_COLS - 1;
      eol = (c + 1 >= cols);
      last_row = (r + 1 >= rows);
      above = 1'b0;
      aboveleft = 1'b0;
      left = 1'b0;
      prior = 1'b0;
      if (r > 0) begin
        above = above_pix[c];
        if (c > 0) aboveleft = above_pix[c-1];
      end
      if (c > 0) left = left_pix;
      if (c >= 2) prior = square_at[c-2];
      sq = p & left & above & aboveleft;
      if (sq) begin
        res = '0;
        res.square_row = POS_W'(r - 1);
        res.square_col = POS_W'(c - 1);
        queue_result(res);
        if (found < SQUARE_LIMIT) found++;
      end
      if (c > 0) begin
        square_at[c-1] = sq;
        // the above-left pixel has seen every square that can hold it
        if (r > 0) mark_uncovered(aboveleft, cover_mark[c-1] | prior | sq);
        mark = prior | sq;
        cover_mark[c-1] = mark;
        if (last_row) mark_uncovered(left, mark);
        above_pix[c-1] = left;
      end
      if (eol) begin
        if (r > 0) mark_uncovered(above, cover_mark[c] | sq);
        cover_mark[c] = sq;
        if (last_row) mark_uncovered(p, sq);
        above_pix[c] = p;
      end
      left_pix = p;
      if (eol && last_row) begin
        res = '0;
        res.is_summary = 1'b1;
        res.all_covered = !uncovered;
        res.square_count = TOTAL_W'(found);
        res.last = 1'b1;
        queue_result(res);
        found = 0;
        uncovered = 1'b0;
        row_pos = 0;
        col_pos = 0;
      end else if (eol) begin
        col_pos = 0;
        row_pos = r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    task log_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task match_result(input result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result row %0d col %0d summary %0b",
                               got.square_row, got.square_col, got.is_summary));
        return;
      end
      want = due_results.pop_front();
      if (got.square_row !== want.square_row)
        log_mismatch($sformatf("square_row %0d, want %0d", got.square_row, want.square_row));
      if (got.square_col !== want.square_col)
        log_mismatch($sformatf("square_col %0d, want %0d", got.square_col, want.square_col));
      if (got.is_summary !== want.is_summary)
        log_mismatch($sformatf("is_summary %0b, want %0b", got.is_summary, want.is_summary));
      if (got.all_covered !== want.all_covered)
        log_mismatch($sformatf("all_covered %0b, want %0b", got.all_covered, want.all_covered));
      if (got.square_count !== want.square_count)
        log_mismatch($sformatf("square_count %0d, want %0d", got.square_count,
                               want.square_count));
      if (got.last !== want.last)
        log_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 pixel;
  logic                 out_valid;
  logic                 out_ready;
  logic [POS_W-1:0]     square_row;
  logic [POS_W-1:0]     square_col;
  logic                 is_summary;
  logic                 all_covered;
  logic [TOTAL_W-1:0]   square_count;
  logic                 last;

  binary_image_2x2_square_cover_check_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel(pixel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .square_row(square_row),
    .square_col(square_col),
    .is_summary(is_summary),
    .all_covered(all_covered),
    .square_count(square_count),
    .last(last)
  );

  square_tracker sb = new();

  // image buffer for the frame being streamed
  bit frame [MAX_ROWS][MAX_COLS];
  int pixels_sent;
  bit in_calm;
  int stall_cycles;
  result_t seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // Present one pixel after an optional gap and hold it until the handshake.
  task automatic send_pixel(input bit p);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_pixel(p);
    pixels_sent++;
  endtask

  // Send the low n bits of a pattern, most significant bit first.
  task automatic send_bits(input logic [15:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_pixel(bits[i]);
  endtask

  // Stream the first n pixels of the frame buffer in row-major order.
  task automatic send_frame(input int n, input int width);
    for (int i = 0; i < n; i++) send_pixel(frame[i / width][i % width]);
  endtask

  // Drop valid, let every owed result drain, then wait out the pipeline so a
  // pixel that owes nothing is also done before a register changes.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Build a frame. Most frames are unions of 2x2 blocks (fully covered),
  // some carry a stray pixel or a hole, the rest are noise, solid or empty.
  task automatic fill_frame(input int rows, input int cols);
    int mode;
    int density;
    int n;
    int r;
    int c;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < MAX_ROWS; i++)
      for (int j = 0; j < MAX_COLS; j++) frame[i][j] = 1'b0;
    if (mode <= 5) begin
      n = $urandom_range(1, rows * cols / 4 + 1);
      repeat (n) begin
        r = $urandom_range(0, rows - 2);
        c = $urandom_range(0, cols - 2);
        frame[r][c] = 1'b1;
        frame[r][c+1] = 1'b1;
        frame[r+1][c] = 1'b1;
        frame[r+1][c+1] = 1'b1;
      end
      r = $urandom_range(0, rows - 1);
      c = $urandom_range(0, cols - 1);
      if (mode == 4) frame[r][c] = 1'b1;
      if (mode == 5) frame[r][c] = 1'b0;
    end else if (mode <= 7) begin
      density = $urandom_range(0, 100);
      for (int i = 0; i < rows; i++)
        for (int j = 0; j < cols; j++) frame[i][j] = ($urandom_range(0, 99) < density);
    end else if (mode == 8) begin
      for (int i = 0; i < rows; i++)
        for (int j = 0; j < cols; j++) frame[i][j] = 1'b1;
    end
  endtask

  // Result monitor: sample at the rising edge, check against the oldest owed result.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.square_row = square_row;
      seen.square_col = square_col;
      seen.is_summary = is_summary;
      seen.all_covered = all_covered;
      seen.square_count = square_count;
      seen.last = last;
      sb.match_result(seen);
    end
  end

  // Consumer: ready runs of random length, stalls mostly short, a few long,
  // and now and then a long stretch with no stall at all.
  initial begin
    int on_len;
    int off_len;
    out_ready = 1'b0;
    forever begin
      if ($urandom_range(0, 7) == 0) on_len = $urandom_range(150, 400);
      else on_len = $urandom_range(1, 12);
      off_len = pick_gap();
      repeat (on_len) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      repeat (off_len) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no item moves on either side for too long.
  initial begin
    stall_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int rows_raw;
    int cols_raw;
    int sel;
    int images;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_ROW_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel = 1'b0;
    pixels_sent = 0;
    in_calm = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: 2x2 solid (square and summary on one pixel), 2x2 with a
    // corner missing (uncovered), 2x2 empty, then 3x3 solid.
    write_reg(CFG_ROW_COUNT, CNT_W'(2));
    write_reg(CFG_COL_COUNT, CNT_W'(2));
    send_bits(16'hF, 4);
    send_bits(16'hE, 4);
    send_bits(16'h0, 4);
    settle();
    write_reg(CFG_ROW_COUNT, CNT_W'(3));
    write_reg(CFG_COL_COUNT, CNT_W'(3));
    send_bits(16'h1FF, 9);

    // Random phases: new image size while idle, then whole frames, and
    // sometimes a frame cut short while a register changes under it.
    phase = 0;
    while (pixels_sent < PIXEL_TARGET) begin
      settle();
      sel = $urandom_range(0, 3);
      case (phase)
        0: begin
          rows_raw = 127;
          cols_raw = 0;
          sel = 2;
        end
        1: begin
          rows_raw = 1;
          cols_raw = 64;
          sel = 2;
        end
        default: begin
          case ($urandom_range(0, 9))
            0: begin
              rows_raw = $urandom_range(64, 127);
              cols_raw = $urandom_range(0, 4);
            end
            1: begin
              rows_raw = $urandom_range(0, 3);
              cols_raw = $urandom_range(64, 127);
            end
            default: begin
              rows_raw = $urandom_range(0, 9);
              cols_raw = $urandom_range(0, 9);
            end
          endcase
        end
      endcase
      if (sel != 1) write_reg(CFG_ROW_COUNT, CNT_W'(rows_raw));
      if (sel != 0) write_reg(CFG_COL_COUNT, CNT_W'(cols_raw));

      images = (sb.rows * sb.cols > 64) ? 1 : $urandom_range(1, 3);
      repeat (images) begin
        in_calm = ($urandom_range(0, 4) == 0);
        fill_frame(sb.rows, sb.cols);
        send_frame(sb.rows * sb.cols, sb.cols);
      end

      if (sb.rows <= 16 && $urandom_range(0, 3) == 0) begin
        in_calm = 1'b0;
        fill_frame(sb.rows, sb.cols);
        send_frame($urandom_range(1, sb.rows * sb.cols - 1), sb.cols);
        settle();
        if ($urandom_range(0, 1) == 0) write_reg(CFG_ROW_COUNT, CNT_W'($urandom_range(0, 10)));
        else write_reg(CFG_COL_COUNT, CNT_W'($urandom_range(0, 10)));
        // finish the broken frame with noise under the new size
        while (!sb.at_frame_start()) send_pixel($urandom_range(0, 1));
      end
      phase++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
